FILE: rtl/qvr_pkg.sv
// Shared widths, constants and register indexes for the quaternion vector rotator.
`timescale 1ns / 1ps
`default_nettype none
package qvr_pkg;

    // Field widths
    localparam int unsigned QW   = 16;           // quaternion component, Q2.14
    localparam int unsigned VW   = 24;           // vector component
    localparam int unsigned M1W  = QW + VW;      // q * v product
    localparam int unsigned PW   = M1W + 2;      // sum of three products
    localparam int unsigned M2W  = QW + PW;      // q * p product
    localparam int unsigned RW   = M2W + 2;      // sum of four products
    localparam int unsigned SHR  = 28;           // final scale shift
    localparam int unsigned SW   = RW - SHR;     // width after shift

    // Rounding bias, half of one output LSB
    localparam logic signed [RW-1:0] RND_BIAS = RW'(64'sd1 <<< (SHR - 1));

    // Output clamp limits
    localparam logic signed [SW-1:0] VEC_MAX = SW'(64'sd8388607);
    localparam logic signed [SW-1:0] VEC_MIN = SW'(-64'sd8388608);

    // Identity scalar part at reset
    localparam logic signed [QW-1:0] ROT_W_RESET = QW'(64'sd16384);

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_ROT_X = 2'd0,
        REG_ROT_Y = 2'd1,
        REG_ROT_Z = 2'd2,
        REG_ROT_W = 2'd3
    } t_reg_idx;

endpackage
`default_nettype wire

FILE: rtl/quaternion_vector_rotate.sv
// Top level: pipelined rotation of 3-vectors by a configured quaternion.
//
// Usage:
//   Slave stream (i_s_axis_*) carries one 3-vector per beat; the master stream
//   (o_m_axis_*) returns the rotated vector and a clip flag per beat, in order.
//   The quaternion (x, y, z, w, each Q2.14) is written through the plain write
//   port i_cfg_we / i_cfg_idx / i_cfg_data while no beat is in flight.
// Pipeline: five register stages: q*v products, first Hamilton sums,
//   p*conj(q) products, second Hamilton sums, round and clamp.
// Throughput: one beat per cycle unless stalled; each stage holds one beat.
// Stalls: every stage has its own valid bit and moves when the stage after it
//   is empty or moving, so a stalled receiver fills the bubbles first and only
//   then drops o_s_axis_tready. Nothing is lost or repeated.
// Reset: i_rst_n (synchronous, low) empties the pipe and sets the quaternion
//   to identity (w = 1.0, x = y = z = 0).
`timescale 1ns / 1ps
`default_nettype none
module quaternion_vector_rotate (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write port
    input  wire logic                          i_cfg_we,
    input  wire qvr_pkg::t_reg_idx             i_cfg_idx,
    input  wire logic [qvr_pkg::QW-1:0]        i_cfg_data,
    // Input stream
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [3*qvr_pkg::VW-1:0]      i_s_axis_tdata,   // in_x, in_y, in_z
    // Output stream
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [3*qvr_pkg::VW-1:0]           o_m_axis_tdata,   // out_x, out_y, out_z
    output logic                               o_m_axis_tuser    // clipped
);
    import qvr_pkg::*;

    // Quaternion registers
    logic signed [QW-1:0] r_rot_x, r_rot_y, r_rot_z, r_rot_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_x <= '0;
            r_rot_y <= '0;
            r_rot_z <= '0;
            r_rot_w <= ROT_W_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROT_X: r_rot_x <= i_cfg_data;
                REG_ROT_Y: r_rot_y <= i_cfg_data;
                REG_ROT_Z: r_rot_z <= i_cfg_data;
                REG_ROT_W: r_rot_w <= i_cfg_data;
                default:   r_rot_w <= r_rot_w;
            endcase
        end
    end

    // Stage valids and per-stage advance
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r_v5 || i_m_axis_tready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // Input unpack
    logic signed [VW-1:0] vx, vy, vz;
    assign vx = i_s_axis_tdata[VW-1:0];
    assign vy = i_s_axis_tdata[2*VW-1:VW];
    assign vz = i_s_axis_tdata[3*VW-1:2*VW];

    // Stage 1: products of q and v
    logic signed [M1W-1:0] r_qxvx, r_qyvy, r_qzvz;
    logic signed [M1W-1:0] r_wvx, r_qyvz, r_qzvy;
    logic signed [M1W-1:0] r_wvy, r_qzvx, r_qxvz;
    logic signed [M1W-1:0] r_wvz, r_qxvy, r_qyvx;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_qxvx <= r_rot_x * vx;
            r_qyvy <= r_rot_y * vy;
            r_qzvz <= r_rot_z * vz;
            r_wvx  <= r_rot_w * vx;
            r_qyvz <= r_rot_y * vz;
            r_qzvy <= r_rot_z * vy;
            r_wvy  <= r_rot_w * vy;
            r_qzvx <= r_rot_z * vx;
            r_qxvz <= r_rot_x * vz;
            r_wvz  <= r_rot_w * vz;
            r_qxvy <= r_rot_x * vy;
            r_qyvx <= r_rot_y * vx;
        end
    end

    // Stage 2: p = q * (v, 0)
    logic signed [PW-1:0] n_pw, n_px, n_py, n_pz;
    logic signed [PW-1:0] r_pw, r_px, r_py, r_pz;

    assign n_pw = -(PW'(r_qxvx) + PW'(r_qyvy) + PW'(r_qzvz));
    assign n_px = PW'(r_wvx) + PW'(r_qyvz) - PW'(r_qzvy);
    assign n_py = PW'(r_wvy) + PW'(r_qzvx) - PW'(r_qxvz);
    assign n_pz = PW'(r_wvz) + PW'(r_qxvy) - PW'(r_qyvx);

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_pw <= n_pw;
            r_px <= n_px;
            r_py <= n_py;
            r_pz <= n_pz;
        end
    end

    // Stage 3: products of p and q
    logic signed [M2W-1:0] r_pwqx, r_wpx, r_pyqz, r_pzqy;
    logic signed [M2W-1:0] r_pwqy, r_wpy, r_pzqx, r_pxqz;
    logic signed [M2W-1:0] r_pwqz, r_wpz, r_pxqy, r_pyqx;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_pwqx <= r_pw * r_rot_x;
            r_wpx  <= r_rot_w * r_px;
            r_pyqz <= r_py * r_rot_z;
            r_pzqy <= r_pz * r_rot_y;
            r_pwqy <= r_pw * r_rot_y;
            r_wpy  <= r_rot_w * r_py;
            r_pzqx <= r_pz * r_rot_x;
            r_pxqz <= r_px * r_rot_z;
            r_pwqz <= r_pw * r_rot_z;
            r_wpz  <= r_rot_w * r_pz;
            r_pxqy <= r_px * r_rot_y;
            r_pyqx <= r_py * r_rot_x;
        end
    end

    // Stage 4: vector part of p * conj(q), with rounding bias folded in
    logic signed [RW-1:0] n_rx, n_ry, n_rz;
    logic signed [RW-1:0] r_rx, r_ry, r_rz;

    assign n_rx = RW'(r_wpx) - RW'(r_pwqx) - RW'(r_pyqz) + RW'(r_pzqy) + RND_BIAS;
    assign n_ry = RW'(r_wpy) - RW'(r_pwqy) - RW'(r_pzqx) + RW'(r_pxqz) + RND_BIAS;
    assign n_rz = RW'(r_wpz) - RW'(r_pwqz) - RW'(r_pxqy) + RW'(r_pyqx) + RND_BIAS;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_rx <= n_rx;
            r_ry <= n_ry;
            r_rz <= n_rz;
        end
    end

    // Stage 5: shift, clamp, flag
    logic signed [SW-1:0] sx, sy, sz;
    logic                 hx, lx, hy, ly, hz, lz;
    logic signed [VW-1:0] n_ox, n_oy, n_oz;
    logic signed [VW-1:0] r_ox, r_oy, r_oz;
    logic                 r_clip;

    assign sx = r_rx[RW-1:SHR];
    assign sy = r_ry[RW-1:SHR];
    assign sz = r_rz[RW-1:SHR];

    assign hx = sx > VEC_MAX;
    assign lx = sx < VEC_MIN;
    assign hy = sy > VEC_MAX;
    assign ly = sy < VEC_MIN;
    assign hz = sz > VEC_MAX;
    assign lz = sz < VEC_MIN;

    assign n_ox = hx ? VEC_MAX[VW-1:0] : (lx ? VEC_MIN[VW-1:0] : sx[VW-1:0]);
    assign n_oy = hy ? VEC_MAX[VW-1:0] : (ly ? VEC_MIN[VW-1:0] : sy[VW-1:0]);
    assign n_oz = hz ? VEC_MAX[VW-1:0] : (lz ? VEC_MIN[VW-1:0] : sz[VW-1:0]);

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_ox   <= n_ox;
            r_oy   <= n_oy;
            r_oz   <= n_oz;
            r_clip <= hx | lx | hy | ly | hz | lz;
        end
    end

    // Output beat
    assign o_m_axis_tvalid = r_v5;
    assign o_m_axis_tdata  = {r_oz, r_oy, r_ox};
    assign o_m_axis_tuser  = r_clip;

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the quaternion vector rotator: directed and random vector streams.
`timescale 1ns / 1ps
module tb_top;
    import qvr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RAND_PHASES = 8;
    localparam int unsigned PHASE_ITEMS = 140;
    localparam int unsigned IDLE_PCT    = 34;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam longint      HALF_LSB    = 64'sd1 <<< (SHR - 1);
    localparam longint      VEC_TOP     = 64'sd8388607;
    localparam longint      VEC_BOT     = -64'sd8388608;
    localparam logic [VW-1:0] V_MAX     = 24'h7FFFFF;
    localparam logic [VW-1:0] V_MIN     = 24'h800000;
    localparam logic [VW-1:0] V_NEG1    = 24'hFFFFFF;

    typedef struct packed {
        logic [VW-1:0] x;
        logic [VW-1:0] y;
        logic [VW-1:0] z;
        logic          clipped;
    } rot_vec_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    t_reg_idx             i_cfg_idx = REG_ROT_X;
    logic [QW-1:0]        i_cfg_data = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [3*VW-1:0]      i_s_axis_tdata = '0;     // in_x, in_y, in_z
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [3*VW-1:0]      o_m_axis_tdata;          // out_x, out_y, out_z
    logic                 o_m_axis_tuser;          // clipped

    // Input vectors waiting for the driver, rotated vectors waiting for the DUT
    logic [3*VW-1:0]      vec_in_q[$];
    rot_vec_t             want_rot_q[$];

    // Quaternion as the DUT should hold it
    logic signed [QW-1:0] quat_x, quat_y, quat_z, quat_w;

    int unsigned          mismatches = 0;
    int unsigned          cycle_cnt = 0;
    logic                 calm = 1'b0;
    logic                 hold_request = 1'b0;
    logic                 hold_taken = 1'b0;
    int unsigned          hold_left = 0;

    quaternion_vector_rotate dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // Shift by 28 with round-half-up, then clamp; bit 24 flags a clamp
    function automatic logic [VW:0] round_clamp(longint acc);
        longint s;
        s = (acc + HALF_LSB) >>> SHR;
        if (s > VEC_TOP) return {1'b1, V_MAX};
        if (s < VEC_BOT) return {1'b1, V_MIN};
        return {1'b0, s[VW-1:0]};
    endfunction

    // Vector part of q * (v, 0) * conj(q), exact in 64 bits
    function automatic rot_vec_t rotate_by_quat(logic [3*VW-1:0] beat);
        longint vx, vy, vz, qx, qy, qz, qw;
        longint pw, px, py, pz, rx, ry, rz;
        logic [VW:0] cx, cy, cz;
        rot_vec_t res;
        vx = longint'($signed(beat[VW-1:0]));
        vy = longint'($signed(beat[2*VW-1:VW]));
        vz = longint'($signed(beat[3*VW-1:2*VW]));
        qx = longint'(quat_x);
        qy = longint'(quat_y);
        qz = longint'(quat_z);
        qw = longint'(quat_w);
        pw = -(qx * vx + qy * vy + qz * vz);
        px = qw * vx + (qy * vz - qz * vy);
        py = qw * vy + (qz * vx - qx * vz);
        pz = qw * vz + (qx * vy - qy * vx);
        rx = -pw * qx + qw * px - (py * qz - pz * qy);
        ry = -pw * qy + qw * py - (pz * qx - px * qz);
        rz = -pw * qz + qw * pz - (px * qy - py * qx);
        cx = round_clamp(rx);
        cy = round_clamp(ry);
        cz = round_clamp(rz);
        res.x = cx[VW-1:0];
        res.y = cy[VW-1:0];
        res.z = cz[VW-1:0];
        res.clipped = cx[VW] | cy[VW] | cz[VW];
        return res;
    endfunction

    // Mix of full-range, small, extreme and near-full-scale components
    function automatic logic [VW-1:0] rand_comp();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60) return VW'($urandom);
        if (sel < 80) return VW'(int'($urandom_range(2000)) - 1000);
        if (sel < 90) begin
            case ($urandom_range(4))
                0: return V_MAX;
                1: return V_MIN;
                2: return '0;
                3: return V_NEG1;
                default: return 24'd1;
            endcase
        end
        return {($urandom_range(1) != 0) ? 2'b01 : 2'b10, 22'($urandom)};
    endfunction

    task automatic push_vec(logic [VW-1:0] x, logic [VW-1:0] y, logic [VW-1:0] z);
        vec_in_q.push_back({z, y, x});
    endtask

    task automatic write_reg(t_reg_idx idx, logic [QW-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_quat(logic [QW-1:0] x, logic [QW-1:0] y, logic [QW-1:0] z,
                            logic [QW-1:0] w);
        write_reg(REG_ROT_X, x);
        write_reg(REG_ROT_Y, y);
        write_reg(REG_ROT_Z, z);
        write_reg(REG_ROT_W, w);
        @(negedge i_clk);
    endtask

    // Block is idle once nothing is queued, offered or outstanding
    task automatic drain();
        do @(negedge i_clk);
        while (vec_in_q.size() != 0 || i_s_axis_tvalid || want_rot_q.size() != 0);
    endtask

    // Sender: hold a beat until taken, random gaps between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (vec_in_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                i_s_axis_tdata  <= vec_in_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else if (hold_request && !hold_taken) begin
            hold_taken      <= 1'b1;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Quaternion tracking, prediction on input beats, checking on output beats
    always @(posedge i_clk) begin
        rot_vec_t want;
        rot_vec_t got;
        if (!i_rst_n) begin
            quat_x = '0;
            quat_y = '0;
            quat_z = '0;
            quat_w = 16'sd16384;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROT_X: quat_x = i_cfg_data;
                    REG_ROT_Y: quat_y = i_cfg_data;
                    REG_ROT_Z: quat_z = i_cfg_data;
                    REG_ROT_W: quat_w = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                want_rot_q.push_back(rotate_by_quat(i_s_axis_tdata));
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.x       = o_m_axis_tdata[VW-1:0];
                got.y       = o_m_axis_tdata[2*VW-1:VW];
                got.z       = o_m_axis_tdata[3*VW-1:2*VW];
                got.clipped = o_m_axis_tuser;
                if (want_rot_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output beat: x=%0d y=%0d z=%0d clipped=%0b",
                                 $signed(got.x), $signed(got.y), $signed(got.z), got.clipped);
                end else begin
                    want = want_rot_q.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                        got.clipped !== want.clipped) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: want x=%0d y=%0d z=%0d clipped=%0b, got x=%0d y=%0d z=%0d clipped=%0b",
                                     $signed(want.x), $signed(want.y), $signed(want.z),
                                     want.clipped, $signed(got.x), $signed(got.y),
                                     $signed(got.z), got.clipped);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        real a, b, c, d, n;
        int unsigned ph, k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Identity quaternion out of reset: vectors pass through
        push_vec('0, '0, '0);
        push_vec(V_MAX, V_MAX, V_MAX);
        push_vec(V_MIN, V_MIN, V_MIN);
        push_vec(24'd1, V_NEG1, '0);
        push_vec(V_MIN, V_MAX, V_NEG1);
        drain();

        // Quarter turn about z
        set_quat(16'sd0, 16'sd0, 16'sd11585, 16'sd11585);
        push_vec(V_MAX, '0, '0);
        push_vec(V_MIN, V_MIN, V_MIN);
        push_vec(24'd1000, 24'(-2000), 24'd3000);
        drain();

        // Non-unit quaternions at both extremes: heavy saturation
        set_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_vec(V_MAX, V_MIN, 24'd1);
        push_vec(24'd1, 24'd1, 24'd1);
        drain();
        set_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        push_vec(V_MIN, V_MIN, V_MIN);
        push_vec(V_MAX, V_NEG1, '0);
        drain();

        // Zero quaternion, then w = -2.0 alone (scale by four)
        set_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        push_vec(V_MAX, V_MIN, V_MAX);
        drain();
        write_reg(REG_ROT_W, 16'h8000);
        @(negedge i_clk);
        push_vec(24'd12345, V_NEG1, 24'd1);
        push_vec(24'h100000, 24'h200000, 24'hE00000);
        drain();

        // w = 2^-7: results land exactly on half an LSB, ties go up
        set_quat(16'sd0, 16'sd0, 16'sd0, 16'sd128);
        push_vec(24'd8192, 24'(-8192), 24'd24576);
        push_vec(24'(-24576), 24'd1, V_NEG1);
        drain();

        // Random phases, each with its own quaternion
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph % 4 == 0) begin
                set_quat(QW'($urandom), QW'($urandom), QW'($urandom), QW'($urandom));
            end else begin
                a = real'(int'($urandom_range(2000)) - 1000);
                b = real'(int'($urandom_range(2000)) - 1000);
                c = real'(int'($urandom_range(2000)) - 1000);
                d = real'(int'($urandom_range(2000)) - 1000);
                n = $sqrt(a * a + b * b + c * c + d * d);
                if (n == 0.0) n = 1.0;
                set_quat(QW'($rtoi(a / n * 16384.0)), QW'($rtoi(b / n * 16384.0)),
                         QW'($rtoi(c / n * 16384.0)), QW'($rtoi(d / n * 16384.0)));
            end
            calm = (ph == 3);
            if (ph == 5) hold_request = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
                push_vec(rand_comp(), rand_comp(), rand_comp());
            drain();
        end
        calm = 1'b0;

        repeat (12) @(posedge i_clk);
        if (mismatches == 0 && want_rot_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
